// ===== rtl/core/nfpq_pkg.sv =====
// ----------------------------------------------------------------------------
// nfpq_pkg
// Shared types and constants of the nearest and farthest point query unit.
// ----------------------------------------------------------------------------
package nfpq_pkg;

  // Default depth of the point store.
  localparam int MAX_POINTS_DEF = 256;

  // Width of one two's complement coordinate.
  localparam int COORD_BITS = 16;

  // Width of a signed coordinate difference.
  localparam int DIFF_BITS  = COORD_BITS + 1;

  // Width of one squared axis distance.
  localparam int SQ_BITS    = 2 * COORD_BITS;

  // Width of a squared Euclidean distance.
  localparam int DIST_BITS  = SQ_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] absdiff_t;
  typedef logic        [SQ_BITS-1:0]    sq_t;
  typedef logic        [DIST_BITS-1:0]  dist_t;

  // Operation codes. Code 3 has no meaning: it changes nothing and yields a zero result.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the query point and reset the best trackers
    logic rd_en;     // read one stored point into the distance pipeline
    logic load_out;  // apply the operation and load the result register
    op_t  op;        // operation of the beat being finished
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;  // a point is still in the distance pipeline
  } status_t;

endpackage

// ===== rtl/core/nearest_farthest_point_query_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_farthest_point_query_unit
// Brute-force nearest and farthest neighbor search over a store of 2D points.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Beat contents
//   -------  --------------------  ------------------------------------------
//   in       in_valid / in_ready   operation, coord_x, coord_y
//   out      out_valid / out_ready answer_valid, set_full, near_x, near_y,
//                                  far_x, far_y
//
// A clear, an add or an unused code goes from acceptance straight to the
// result register. A query first scans: it reads one point per cycle from the
// single-port store, and its result is loaded once the distance pipeline
// (read, difference, square, compare) has drained.
// One operation is worked on at a time; in_ready is high only while the unit
// waits for a beat. A result that is not taken holds in the output register,
// and the next input beat is still accepted, then waits for that register.
// Reset is synchronous and empties the store; stored points need no clearing.
// ----------------------------------------------------------------------------
module nearest_farthest_point_query_unit #(
  parameter int MAX_POINTS = nfpq_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  nfpq_pkg::coord_t   coord_x,
  input  nfpq_pkg::coord_t   coord_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               answer_valid,
  output logic               set_full,
  output nfpq_pkg::coord_t   near_x,
  output nfpq_pkg::coord_t   near_y,
  output nfpq_pkg::coord_t   far_x,
  output nfpq_pkg::coord_t   far_y
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  nfpq_pkg::cmd_t    cmd;
  nfpq_pkg::status_t status;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  rd_addr;

  // The controller sequences each beat: it issues one store read per cycle
  // during a query and loads the result register once the pipeline drains.
  nfpq_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .count     (count),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  // The datapath holds the points, computes squared distances and tracks
  // the nearest and farthest points seen so far.
  nfpq_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .status       (status),
    .count        (count),
    .answer_valid (answer_valid),
    .set_full     (set_full),
    .near_x       (near_x),
    .near_y       (near_y),
    .far_x        (far_x),
    .far_y        (far_y)
  );

  // The point count never runs past the depth of the store.
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count exceeds store depth");

  // A result is never both a query answer and a dropped add.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(answer_valid && set_full))
    else $error("answer and full flag raised together");

  // A dropped add is only reported while the store is full.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && set_full) |-> (count == CNT_W'(MAX_POINTS)))
    else $error("full flag raised with room in the store");

  // A query beat closes the input until its scan is done.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (operation == nfpq_pkg::OP_QUERY)) |=> !in_ready)
    else $error("input accepted during a scan");

endmodule

// ===== rtl/core/nfpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// nfpq_ctrl
// Controller: sequences input beats, the scan over stored points and results.
// ----------------------------------------------------------------------------
module nfpq_ctrl #(
  parameter int MAX_POINTS = nfpq_pkg::MAX_POINTS_DEF,
  localparam int CNT_W = $clog2(MAX_POINTS + 1),
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           operation,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  nfpq_pkg::status_t    status,
  input  logic [CNT_W-1:0]     count,
  output nfpq_pkg::cmd_t       cmd,
  output logic [IDX_W-1:0]     rd_addr
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t             state;
  nfpq_pkg::op_t      op;
  logic [CNT_W-1:0]   idx;
  logic               accept;
  logic               issue;
  logic               out_free;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign issue    = (state == ST_SCAN) && (idx < count);
  assign out_free = !out_valid || out_ready;

  assign rd_addr      = idx[IDX_W-1:0];
  assign cmd.capture  = accept;
  assign cmd.rd_en    = issue;
  assign cmd.load_out = (state == ST_FINISH) && out_free;
  assign cmd.op       = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= nfpq_pkg::OP_CLEAR;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op  <= nfpq_pkg::op_t'(operation);
            idx <= '0;
            if (nfpq_pkg::op_t'(operation) == nfpq_pkg::OP_QUERY) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end else if (!status.pipe_busy) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/nfpq_dpath.sv =====
// ----------------------------------------------------------------------------
// nfpq_dpath
// Datapath: point store, distance pipeline, best trackers and result register.
// ----------------------------------------------------------------------------
module nfpq_dpath #(
  parameter int MAX_POINTS = nfpq_pkg::MAX_POINTS_DEF,
  localparam int CNT_W = $clog2(MAX_POINTS + 1),
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  nfpq_pkg::coord_t         coord_x,
  input  nfpq_pkg::coord_t         coord_y,
  input  nfpq_pkg::cmd_t           cmd,
  input  logic [IDX_W-1:0]         rd_addr,
  output nfpq_pkg::status_t        status,
  output logic [CNT_W-1:0]         count,
  output logic                     answer_valid,
  output logic                     set_full,
  output nfpq_pkg::coord_t         near_x,
  output nfpq_pkg::coord_t         near_y,
  output nfpq_pkg::coord_t         far_x,
  output nfpq_pkg::coord_t         far_y
);

  localparam int CW = nfpq_pkg::COORD_BITS;

  // Each entry holds {x, y}.
  logic [2*CW-1:0] mem [MAX_POINTS];

  nfpq_pkg::coord_t   qx, qy;
  logic               full;

  // Stage 1: registered read data.
  logic               s1_vld;
  logic [2*CW-1:0]    s1_pt;
  // Stage 2: absolute differences.
  logic               s2_vld;
  nfpq_pkg::absdiff_t s2_dx, s2_dy;
  nfpq_pkg::coord_t   s2_x, s2_y;
  // Stage 3: squares.
  logic               s3_vld;
  nfpq_pkg::sq_t      s3_sx, s3_sy;
  nfpq_pkg::coord_t   s3_x, s3_y;

  // Best trackers.
  logic               have_near;
  nfpq_pkg::dist_t    best_near, best_far;
  nfpq_pkg::coord_t   nx, ny, fx, fy;

  logic signed [nfpq_pkg::DIFF_BITS-1:0] diff_x, diff_y;
  nfpq_pkg::coord_t   px, py;
  nfpq_pkg::dist_t    sq_dist;

  assign full             = (count == CNT_W'(MAX_POINTS));
  assign status.pipe_busy = s1_vld || s2_vld || s3_vld;

  assign px      = s1_pt[2*CW-1:CW];
  assign py      = s1_pt[CW-1:0];
  assign diff_x  = {px[CW-1], px} - {qx[CW-1], qx};
  assign diff_y  = {py[CW-1], py} - {qy[CW-1], qy};
  assign sq_dist = {1'b0, s3_sx} + {1'b0, s3_sy};

  // Store and point count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load_out) begin
      case (cmd.op)
        nfpq_pkg::OP_CLEAR: count <= '0;
        nfpq_pkg::OP_ADD: begin
          if (!full) begin
            count <= count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out && (cmd.op == nfpq_pkg::OP_ADD) && !full) begin
      mem[count[IDX_W-1:0]] <= {qx, qy};
    end
    if (cmd.rd_en) begin
      s1_pt <= mem[rd_addr];
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      s1_vld <= cmd.rd_en;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  // Distance pipeline payload.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qx <= coord_x;
      qy <= coord_y;
    end
    s2_dx <= diff_x[nfpq_pkg::DIFF_BITS-1] ? CW'(-diff_x) : CW'(diff_x);
    s2_dy <= diff_y[nfpq_pkg::DIFF_BITS-1] ? CW'(-diff_y) : CW'(diff_y);
    s2_x  <= px;
    s2_y  <= py;
    s3_sx <= nfpq_pkg::SQ_BITS'(s2_dx) * nfpq_pkg::SQ_BITS'(s2_dx);
    s3_sy <= nfpq_pkg::SQ_BITS'(s2_dy) * nfpq_pkg::SQ_BITS'(s2_dy);
    s3_x  <= s2_x;
    s3_y  <= s2_y;
  end

  // First strict minimum and first strict maximum above zero.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      have_near <= 1'b0;
      best_near <= '0;
      best_far  <= '0;
      nx        <= '0;
      ny        <= '0;
      fx        <= '0;
      fy        <= '0;
    end else if (s3_vld) begin
      if (!have_near || (sq_dist < best_near)) begin
        have_near <= 1'b1;
        best_near <= sq_dist;
        nx        <= s3_x;
        ny        <= s3_y;
      end
      if (sq_dist > best_far) begin
        best_far <= sq_dist;
        fx       <= s3_x;
        fy       <= s3_y;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      answer_valid <= (cmd.op == nfpq_pkg::OP_QUERY);
      set_full     <= (cmd.op == nfpq_pkg::OP_ADD) && full;
      if (cmd.op == nfpq_pkg::OP_QUERY) begin
        near_x <= nx;
        near_y <= ny;
        far_x  <= fx;
        far_y  <= fy;
      end else begin
        near_x <= '0;
        near_y <= '0;
        far_x  <= '0;
        far_y  <= '0;
      end
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the nearest and farthest point query unit.
// Each accepted input beat is run through an in-bench predictor of the point
// store, and each result beat is compared field by field with the oldest
// pending answer. Directed cases come first. Random episodes follow: clear,
// load a set, then query it. Each phase sets its own idle rates on the
// sender and the receiver. One phase opens with a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef nfpq_pkg::coord_t coord_t;

  localparam logic [1:0] OP_CLEAR = nfpq_pkg::OP_CLEAR;
  localparam logic [1:0] OP_ADD   = nfpq_pkg::OP_ADD;
  localparam logic [1:0] OP_QUERY = nfpq_pkg::OP_QUERY;

  // The point store depth of the unit as instantiated (its default).
  localparam int STORE_DEPTH = nfpq_pkg::MAX_POINTS_DEF;

  // Code 3 is not in the package enum. The unit must answer it with an all-zero
  // result and leave the store alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Random beats per phase, not counting the ignored code.
  localparam int PHASE_BEATS = 550;

  // One result beat, in port order.
  typedef struct packed {
    logic   answer_valid;
    logic   set_full;
    coord_t near_x;
    coord_t near_y;
    coord_t far_x;
    coord_t far_y;
  } answer_t;

  // --------------------------------------------------------------------------
  // Scoreboard. It keeps its own copy of the point store and point count. For
  // every accepted beat it works out the answer the unit owes. It then checks
  // result beats against those answers in order.
  // --------------------------------------------------------------------------
  class neighbor_scoreboard;
    coord_t      pt_x [STORE_DEPTH];
    coord_t      pt_y [STORE_DEPTH];
    int unsigned pt_count;
    answer_t     pending_answers [$];
    int unsigned errors;
    int unsigned answers_checked;
    int unsigned queries_seen;
    int unsigned adds_dropped;

    function new();
      pt_count        = 0;
      errors          = 0;
      answers_checked = 0;
      queries_seen    = 0;
      adds_dropped    = 0;
    endfunction

    // Squared Euclidean distance. It is exact in 64 bits for 16-bit coordinates.
    function longint unsigned dist_sq(coord_t ax, coord_t ay, coord_t bx, coord_t by);
      longint dx;
      longint dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      return longint'(dx * dx + dy * dy);
    endfunction

    function void note_beat(logic [1:0] op, coord_t qx, coord_t qy);
      answer_t           ans;
      longint unsigned   d;
      longint unsigned   best_near;
      longint unsigned   best_far;
      bit                have_near;
      ans       = '0;
      best_near = 0;
      best_far  = 0;
      have_near = 1'b0;
      case (op)
        OP_CLEAR: pt_count = 0;
        OP_ADD: begin
          if (pt_count >= STORE_DEPTH) begin
            ans.set_full = 1'b1;
            adds_dropped++;
          end else begin
            pt_x[pt_count] = qx;
            pt_y[pt_count] = qy;
            pt_count++;
          end
        end
        OP_QUERY: begin
          // Strict compares, so the earliest point in load order wins a tie. The
          // farthest point must lie strictly above zero distance.
          queries_seen++;
          ans.answer_valid = 1'b1;
          for (int unsigned i = 0; i < pt_count; i++) begin
            d = dist_sq(pt_x[i], pt_y[i], qx, qy);
            if (!have_near || d < best_near) begin
              have_near  = 1'b1;
              best_near  = d;
              ans.near_x = pt_x[i];
              ans.near_y = pt_y[i];
            end
            if (d > best_far) begin
              best_far  = d;
              ans.far_x = pt_x[i];
              ans.far_y = pt_y[i];
            end
          end
        end
        default: ;
      endcase
      pending_answers.push_back(ans);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        if (errors < 10) begin
          $display("tb: result %0d field %s: expected %0d, got %0d",
                   answers_checked, name, $signed(want), $signed(got));
        end
        errors++;
      end
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (pending_answers.size() == 0) begin
        if (errors < 10) begin
          $display("tb: result beat arrived with no answer pending");
        end
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      compare_field("answer_valid", 16'(want.answer_valid), 16'(got.answer_valid));
      compare_field("set_full", 16'(want.set_full), 16'(got.set_full));
      compare_field("near_x", want.near_x, got.near_x);
      compare_field("near_y", want.near_y, got.near_y);
      compare_field("far_x", want.far_x, got.far_x);
      compare_field("far_y", want.far_y, got.far_y);
      answers_checked++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the unit.
  // --------------------------------------------------------------------------
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic [1:0]   operation = OP_CLEAR;
  coord_t       coord_x = '0;
  coord_t       coord_y = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic         answer_valid;
  logic         set_full;
  coord_t       near_x;
  coord_t       near_y;
  coord_t       far_x;
  coord_t       far_y;

  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  logic         pressure_go = 1'b0;
  logic         hold_off = 1'b0;
  int unsigned  beats_sent = 0;

  neighbor_scoreboard sb = new();

  initial begin
    forever #5 clk = ~clk;
  end

  nearest_farthest_point_query_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .answer_valid (answer_valid),
    .set_full     (set_full),
    .near_x       (near_x),
    .near_y       (near_y),
    .far_x        (far_x),
    .far_y        (far_y)
  );

  // --------------------------------------------------------------------------
  // Monitor. Everything here is sampled at the rising edge, so it sees the
  // values from before the edge. The input beat is noted before the result
  // is checked. A result can then never overtake the beat that caused it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_beat(operation, coord_x, coord_y);
      end
      if (out_valid && out_ready) begin
        sb.check_answer({answer_valid, set_full, near_x, near_y, far_x, far_y});
      end
    end
  end

  // Receiver. It takes results at random at the current idle rate. It takes
  // none while the hold-off below is active.
  always @(posedge clk) begin
    if (rst || hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off. The sender keeps offering beats meanwhile. The
  // unit then holds one result, takes one more beat and has to drop in_ready.
  initial begin
    do @(posedge clk); while (!pressure_go);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Hard limit, far above the slowest correct run, even with every query
  // scanning a full store.
  initial begin
    #30_000_000;
    $display("tb: timeout with %0d answers still pending", sb.pending_answers.size());
    $display("tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender. It is called at a rising edge and returns at the edge where the
  // beat is accepted. Valid is lowered only when an idle cycle actually
  // follows. A back-to-back beat never sees valid dropped and raised in one step.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic [1:0] op, input coord_t x, input coord_t y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    coord_x   <= x;
    coord_y   <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_UNUSED) beats_sent++;
  endtask

  // The coordinate mix leans on a tiny cluster, so that distances tie and
  // repeat. It also leans on the range ends, so that the squared distance
  // reaches its top bit.
  function automatic coord_t pick_coord();
    case ($urandom_range(7))
      0, 1: return coord_t'(int'($urandom_range(6)) - 3);
      2: begin
        case ($urandom_range(5))
          0:       return coord_t'(16'h8000);
          1:       return coord_t'(16'h8001);
          2:       return coord_t'(16'hFFFF);
          3:       return coord_t'(16'h0000);
          4:       return coord_t'(16'h7FFE);
          default: return coord_t'(16'h7FFF);
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  // One well-formed episode: an optional clear, a loaded set with a few
  // queries mixed in, then queries against the set. Some query points sit
  // exactly on a stored point, so the far search can see a zero distance. A
  // fill episode loads past the store depth, so the last adds are dropped.
  task automatic run_episode(input bit fill_up);
    coord_t      ex [$];
    coord_t      ey [$];
    int unsigned n_adds;
    int unsigned n_queries;
    int unsigned k;
    coord_t      qx;
    coord_t      qy;
    if ($urandom_range(9) != 0) send_beat(OP_CLEAR, pick_coord(), pick_coord());
    if ($urandom_range(29) == 0) send_beat(OP_QUERY, pick_coord(), pick_coord());
    n_adds    = fill_up ? STORE_DEPTH + $urandom_range(1, 4) : $urandom_range(0, 14);
    n_queries = $urandom_range(1, 4);
    for (int i = 0; i < n_adds; i++) begin
      qx = pick_coord();
      qy = pick_coord();
      ex.push_back(qx);
      ey.push_back(qy);
      send_beat(OP_ADD, qx, qy);
      if ($urandom_range(fill_up ? 60 : 5) == 0) send_beat(OP_QUERY, pick_coord(), pick_coord());
      if ($urandom_range(39) == 0) send_beat(OP_UNUSED, pick_coord(), pick_coord());
    end
    for (int j = 0; j < n_queries; j++) begin
      if (ex.size() != 0 && $urandom_range(2) == 0) begin
        k  = $urandom_range(ex.size() - 1);
        qx = ex[k];
        qy = ey[k];
      end else begin
        qx = pick_coord();
        qy = pick_coord();
      end
      send_beat(OP_QUERY, qx, qy);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned episode;
    int unsigned goal;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The receiver is always ready here.
    // A query on the empty set gets the default point for both answers.
    send_beat(OP_QUERY, coord_t'(16'h0000), coord_t'(16'h0000));
    // The unused code with all coordinate bits set must leave the set empty.
    send_beat(OP_UNUSED, coord_t'(16'hFFFF), coord_t'(16'hFFFF));
    send_beat(OP_QUERY, coord_t'(16'h7FFF), coord_t'(16'h8000));
    // A single point, queried on itself: nearest is that point, and the farthest
    // stays at the default because no distance is above zero.
    send_beat(OP_ADD, coord_t'(16'h8000), coord_t'(16'h8000));
    send_beat(OP_QUERY, coord_t'(16'h8000), coord_t'(16'h8000));
    // Opposite corners. From a third corner both are equally far, so the first
    // one loaded wins both searches. From one corner the other is the largest
    // distance possible.
    send_beat(OP_ADD, coord_t'(16'h7FFF), coord_t'(16'h7FFF));
    send_beat(OP_QUERY, coord_t'(16'h7FFF), coord_t'(16'h8000));
    send_beat(OP_QUERY, coord_t'(16'h8000), coord_t'(16'h8000));
    send_beat(OP_QUERY, coord_t'(16'h7FFF), coord_t'(16'h7FFF));
    // Three points at equal distance from the origin: the earliest wins on ties.
    send_beat(OP_CLEAR, coord_t'(16'h7FFF), coord_t'(16'h7FFF));
    send_beat(OP_ADD, coord_t'(16'h0001), coord_t'(16'h0001));
    send_beat(OP_ADD, coord_t'(16'hFFFF), coord_t'(16'hFFFF));
    send_beat(OP_ADD, coord_t'(16'h0001), coord_t'(16'hFFFF));
    send_beat(OP_QUERY, coord_t'(16'h0000), coord_t'(16'h0000));
    send_beat(OP_QUERY, coord_t'(16'h0001), coord_t'(16'h0001));
    // After a clear, a query sees an empty set again.
    send_beat(OP_CLEAR, coord_t'(16'h8000), coord_t'(16'h0000));
    send_beat(OP_QUERY, coord_t'(16'h0005), coord_t'(16'h0005));
    send_beat(OP_ADD, coord_t'(16'h0000), coord_t'(16'h0000));
    send_beat(OP_QUERY, coord_t'(16'h0000), coord_t'(16'h0000));
    send_beat(OP_UNUSED, coord_t'(16'h0000), coord_t'(16'h0000));
    send_beat(OP_QUERY, coord_t'(16'hFFFF), coord_t'(16'h0000));

    // Random part in three phases. The sender idles often while the receiver
    // idles more. Then the two rates swap. Then neither idles, apart from the
    // long hold-off at the start of the last phase. Each phase has one fill
    // episode, so adds are dropped on a full store and full scans run under
    // every idling pattern.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct <= 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct <= 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          pressure_go   <= 1'b1;
          send_beat(OP_CLEAR, pick_coord(), pick_coord());
          for (int i = 0; i < 24; i++) begin
            send_beat(($urandom_range(3) == 0) ? OP_QUERY : OP_ADD, pick_coord(), pick_coord());
          end
        end
      endcase
      goal    = beats_sent + PHASE_BEATS;
      episode = 0;
      while (beats_sent < goal) begin
        run_episode(episode == 2);
        episode++;
      end
    end

    in_valid <= 1'b0;

    // Drain the last answers, then leave room for anything stray.
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (STORE_DEPTH + 40) @(posedge clk);

    if (sb.pending_answers.size() != 0) begin
      $display("tb: %0d answers never arrived", sb.pending_answers.size());
      sb.errors += sb.pending_answers.size();
    end
    $display("tb: %0d beats sent, %0d results checked, %0d of them query answers",
             beats_sent, sb.answers_checked, sb.queries_seen);
    $display("tb: %0d adds dropped on a full store, %0d failures",
             sb.adds_dropped, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/nfpq_pkg.sv
rtl/core/nfpq_ctrl.sv
rtl/core/nfpq_dpath.sv
rtl/core/nearest_farthest_point_query_unit.sv
tb/sv/tb.sv
